// File: rtl/msb_first_bit_packer_core_macros.svh
// msb_first_bit_packer_core_macros.svh: assertion macros for the bit packer
// expects signals named clock and reset in the module that uses them
`ifndef MSB_FIRST_BIT_PACKER_CORE_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_CORE_MACROS_SVH

// property checked every cycle outside reset
`define MBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define MBP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mbp_pkg.sv
// mbp_pkg.sv: shared types and constants of the msb-first bit packer
// no dependencies
`timescale 1ns / 1ps

package mbp_pkg;

   // field widths
   localparam int VALUE_W  = 64;
   localparam int NBITS_W  = 7;
   localparam int BYTE_W   = 8;
   localparam int PCNT_W   = 3;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_PAD_BIT = 1'b0;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one classified request waiting for the back end
   typedef struct packed {
      logic                 flush;
      logic [VALUE_W-1:0]   value;
      logic [NBITS_W-1:0]   nbits;
   } mbp_entry_type;

endpackage

// File: rtl/mbp_req_if.sv
// mbp_req_if.sv: request channel (valid/ready plus write or flush payload)
// depends on mbp_pkg
`timescale 1ns / 1ps

interface mbp_req_if
   import mbp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               command;
   logic [VALUE_W-1:0] value;
   logic [NBITS_W-1:0] num_bits;

   modport source (output valid, command, value, num_bits, input ready);
   modport sink   (input valid, command, value, num_bits, output ready);
endinterface

// File: rtl/mbp_rsp_if.sv
// mbp_rsp_if.sv: result channel (valid/ready plus packed byte and last flag)
// depends on mbp_pkg
`timescale 1ns / 1ps

interface mbp_rsp_if
   import mbp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: rtl/mbp_queue.sv
// mbp_queue.sv: two-entry queue of classified requests between front and back
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_queue
   import mbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mbp_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output mbp_entry_type head_entry
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mbp_entry_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

// File: rtl/mbp_front.sv
// mbp_front.sv: accepts requests, clamps the bit count, masks the code, drops empty writes
// depends on mbp_pkg, mbp_req_if
`timescale 1ns / 1ps

module mbp_front
   import mbp_pkg::*;
#(
   parameter int MAX_CODE_BITS = 64
) (
   mbp_req_if.sink       req_chan,
   input  logic          queue_full,
   output logic          push,
   output mbp_entry_type push_entry
);
   logic [NBITS_W-1:0] nbits_sat;
   logic [VALUE_W-1:0] value_mask;
   logic               is_flush;
   logic               empty_write;

   // saturate the count and keep only the low bits of the code
   always_comb begin
      nbits_sat = (req_chan.num_bits > NBITS_W'(MAX_CODE_BITS)) ?
                  NBITS_W'(MAX_CODE_BITS) : req_chan.num_bits;
      if (nbits_sat == '0) begin
         value_mask = '0;
      end else begin
         value_mask = {VALUE_W{1'b1}} >> (NBITS_W'(VALUE_W) - nbits_sat);
      end
   end

   // classify: flush, write, or a write of no bits which has no effect
   assign is_flush    = (req_chan.command == CMD_FLUSH);
   assign empty_write = !is_flush && (nbits_sat == '0);

   assign req_chan.ready   = !queue_full;
   assign push             = req_chan.valid && !queue_full && !empty_write;
   assign push_entry.flush = is_flush;
   assign push_entry.value = req_chan.value & value_mask;
   assign push_entry.nbits = nbits_sat;
endmodule

// File: rtl/mbp_back.sv
// mbp_back.sv: merges codes with the pending partial byte and emits bytes one per cycle while rsp is not stalled
// depends on mbp_pkg, mbp_rsp_if, msb_first_bit_packer_core_macros.svh
`timescale 1ns / 1ps
`include "msb_first_bit_packer_core_macros.svh"

module mbp_back
   import mbp_pkg::*;
#(
   parameter int MAX_CODE_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  mbp_entry_type head_entry,
   output logic          pop,
   input  logic          pad_bit,
   mbp_rsp_if.source     rsp_chan
);
   localparam int WORK_W = MAX_CODE_BITS + PCNT_W + 4;
   localparam int REM_W  = $clog2(WORK_W + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic              st_ff, st_in;
   logic [WORK_W-1:0] work_ff, work_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [BYTE_W-1:0] pend_ff, pend_in;
   logic [PCNT_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              emit;
   logic [REM_W-1:0]  total;
   logic [WORK_W-1:0] merged;
   logic [BYTE_W-1:0] pad_fill;
   logic [BYTE_W-1:0] flush_byte;
   logic [REM_W-1:0]  rem_after;
   logic [REM_W-1:0]  shamt;
   logic [3:0]        keep_sh;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (st_ff == ST_IDLE) && head_valid;
   assign emit     = (st_ff == ST_EMIT) && out_free;

   // merge the pending bits ahead of the new code, right aligned
   assign merged = (WORK_W'(pend_ff) << head_entry.nbits) | WORK_W'(head_entry.value);
   assign total  = REM_W'(cnt_ff) + REM_W'(head_entry.nbits);

   // padded byte for a flush
   assign pad_fill   = pad_bit ? (8'hFF >> cnt_ff) : '0;
   assign flush_byte = (pend_ff << (4'd8 - 4'(cnt_ff))) | pad_fill;

   // next byte is the top eight of the remaining bits
   assign shamt     = rem_ff - REM_W'(BYTE_W);
   assign rem_after = shamt;
   assign keep_sh   = 4'd8 - 4'(rem_after);

   // sequencer: load one queued request, then emit any whole bytes it completes, or the padded byte of a flush
   always_comb begin
      st_in        = st_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (pop) begin
               if (head_entry.flush) begin
                  if (cnt_ff != '0) begin
                     work_in = WORK_W'(flush_byte);
                     rem_in  = REM_W'(BYTE_W);
                     st_in   = ST_EMIT;
                  end
               end else if (total < REM_W'(BYTE_W)) begin
                  pend_in = merged[BYTE_W-1:0];
                  cnt_in  = total[PCNT_W-1:0];
               end else begin
                  work_in = merged;
                  rem_in  = total;
                  st_in   = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = BYTE_W'(work_ff >> shamt);
               rsp_last_in  = (rem_after < REM_W'(BYTE_W));
               rem_in       = rem_after;
               if (rem_after < REM_W'(BYTE_W)) begin
                  pend_in = work_ff[BYTE_W-1:0] & (8'hFF >> keep_sh);
                  cnt_in  = rem_after[PCNT_W-1:0];
                  st_in   = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         st_ff        <= st_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // checks
   `MBP_ASSERT(a_emit_has_byte, !emit || (rem_ff >= REM_W'(BYTE_W)), "emit with under a byte left")
   `MBP_ASSERT_NEXT(a_last_ends_item, emit && (rem_ff < REM_W'(2 * BYTE_W)), st_ff == ST_IDLE && rsp_chan.last, "last byte did not end the request")
   `MBP_ASSERT_NEXT(a_flush_one_byte, pop && head_entry.flush && (cnt_ff != '0), st_ff == ST_EMIT && rem_ff == REM_W'(BYTE_W), "flush did not load one padded byte")
endmodule

// File: rtl/msb_first_bit_packer_core.sv
// MSB-first bit packer. The first byte of a request passes through the queue, the back end work register
// and the byte output register before it appears on rsp. A write producing k bytes takes one load step,
// then its k bytes; writes producing no byte and empty flushes take only the load step, zero-bit writes none.
// Throughput is set by the single byte output register: one byte per cycle while rsp is not stalled.
// Synchronous active-high reset clears pending bits, pad bit, queue and output valid.
// depends on mbp_pkg, mbp_req_if, mbp_rsp_if, mbp_queue, mbp_front, mbp_back
`timescale 1ns / 1ps

module msb_first_bit_packer_core
   import mbp_pkg::*;
#(
   parameter int MAX_CODE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   mbp_req_if.sink               req_chan,
   mbp_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   logic          pad_ff, pad_in;
   logic          csr_wr;
   logic          reg_index;
   logic          q_full;
   logic          q_push;
   mbp_entry_type q_push_entry;
   logic          q_pop;
   logic          q_head_valid;
   mbp_entry_type q_head_entry;

   // configuration register
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      pad_in = pad_ff;
      if (csr_wr && reg_index == REG_PAD_BIT) begin
         pad_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= 1'b0;
      end else begin
         pad_ff <= pad_in;
      end
   end

   assign csr_prdata = (reg_index == REG_PAD_BIT) ? CSR_DATA_W'(pad_ff) : '0;

   // front end
   mbp_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // request queue
   mbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   // back end
   mbp_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .pad_bit    (pad_ff),
      .rsp_chan   (rsp_chan)
   );
endmodule
